// ===== design/qcci_pkg.sv =====
package qcci_pkg;

	// Block configuration
	localparam int BARREL_COUNTERS  = 176;
	localparam int ENDCAP_COUNTERS  = 96;
	localparam int COEF_FRAC_BITS   = 32;
	localparam int CHARGE_FRAC_BITS = 16;

	// Field widths
	localparam int COEF_W    = 48;
	localparam int CHARGE_W  = 32;
	localparam int COUNTER_W = 8;
	localparam int SECTION_W = 2;
	localparam int CIDX_W    = 2;

	// Coefficient store address widths
	localparam int EC_AW = (ENDCAP_COUNTERS > 1) ? $clog2(ENDCAP_COUNTERS) : 1;
	localparam int BR_AW = (BARREL_COUNTERS > 1) ? $clog2(BARREL_COUNTERS) : 1;

	// Common scale of all terms
	localparam int S_COMMON = (COEF_FRAC_BITS >= CHARGE_FRAC_BITS) ? COEF_FRAC_BITS
		: CHARGE_FRAC_BITS;
	localparam int SA = S_COMMON - COEF_FRAC_BITS;
	localparam int SQ = S_COMMON - CHARGE_FRAC_BITS;

	// Datapath widths
	localparam int AW   = COEF_W + 3 + SA;               // A = 5a, B = 5b, signed
	localparam int QW   = CHARGE_W + 1 + SQ;             // 2q on common scale
	localparam int MW   = ((AW > QW) ? AW : QW) + 1;     // C signed, all magnitudes
	localparam int HW   = (MW + 1) / 2;                  // multiplier half width
	localparam int PPW  = 2 * HW;                        // partial product width
	localparam int PW   = 2 * MW;                        // full product width
	localparam int DW   = PW + 3;                        // discriminant, signed
	localparam int SQIN = DW - 1;                        // discriminant magnitude
	localparam int RB   = SQIN / 2;                      // root bits
	localparam int RW   = RB + 2;                        // root remainder width
	localparam int NW   = ((RB + 1 > AW) ? RB + 1 : AW) + 1;  // N = root - B, signed
	localparam int NUMW = NW + CHARGE_FRAC_BITS + 1;     // rounded numerator
	localparam int DVW  = MW + 1;                        // divisor 2|A|
	localparam int QB   = 33;                            // quotient bits kept
	localparam int TW   = NUMW - QB;                     // numerator bits above quotient
	localparam int CMPW = (TW > DVW) ? TW : DVW;

	// Queue
	localparam int FIFO_DEPTH = 2;
	localparam int FA         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	// Edges from accept to the edge that takes the result
	localparam int LATENCY = RB + QB + 11;

	// Item kinds
	localparam logic KIND_CONV = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// Sections
	localparam logic [SECTION_W-1:0] SEC_ENDCAP = 2'd0;
	localparam logic [SECTION_W-1:0] SEC_EAST   = 2'd1;
	localparam logic [SECTION_W-1:0] SEC_WEST   = 2'd2;

	// Coefficient indexes
	localparam logic [CIDX_W-1:0] CI_CONST = 2'd0;
	localparam logic [CIDX_W-1:0] CI_LIN   = 2'd1;
	localparam logic [CIDX_W-1:0] CI_QUAD  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_NEGD  = 2'd2;
	localparam logic [1:0] ST_ZEROA = 2'd3;

	function automatic logic [CHARGE_W-1:0] sat32(input longint v);
		logic [CHARGE_W-1:0] r;
		if (v > longint'(32'sh7FFF_FFFF)) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -longint'(64'h8000_0000)) begin
			r = 32'h8000_0000;
		end else begin
			r = v[CHARGE_W-1:0];
		end
		return r;
	endfunction

	// Marker and error charges
	localparam longint ERR_L     = -999 * (longint'(1) << CHARGE_FRAC_BITS);
	localparam longint MARK_HI_L = 10000 * (longint'(1) << CHARGE_FRAC_BITS);
	localparam logic [CHARGE_W-1:0] ERR_VAL = sat32(ERR_L);

	// Per-item control carried down the pipe
	typedef struct packed {
		logic                valid;
		logic                done;
		logic [1:0]          status;
		logic [CHARGE_W-1:0] value;
	} ctl_t;

	// Item handed from front to back
	typedef struct packed {
		ctl_t                ctl;
		logic [COEF_W-1:0]   a;
		logic [COEF_W-1:0]   b;
		logic [COEF_W-1:0]   c0;
		logic [CHARGE_W-1:0] q;
	} fe_item_t;

	// Operands kept for the final division
	typedef struct packed {
		logic signed [AW-1:0] b;
		logic [MW-1:0]        mag_a;
		logic                 s_a;
	} carry_t;

endpackage

// ===== design/qcci_front.sv =====
module qcci_front (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      take,
	input  logic                                      kind,
	input  logic [qcci_pkg::SECTION_W-1:0]            section,
	input  logic [qcci_pkg::COUNTER_W-1:0]            counter,
	input  logic [qcci_pkg::CIDX_W-1:0]               coef_index,
	input  logic signed [qcci_pkg::COEF_W-1:0]        coef_value,
	input  logic signed [qcci_pkg::CHARGE_W-1:0]      charge_in,
	output qcci_pkg::fe_item_t                        item
);

	logic ec_ok, br_ok, in_range, is_load, is_conv;
	logic wr_ec, wr_ea, wr_we, rd_ec, rd_ea, rd_we;
	logic [qcci_pkg::EC_AW-1:0] ec_addr;
	logic [qcci_pkg::BR_AW-1:0] br_addr;
	logic [qcci_pkg::COEF_W-1:0] ec_rd [3];
	logic [qcci_pkg::COEF_W-1:0] ea_rd [3];
	logic [qcci_pkg::COEF_W-1:0] we_rd [3];
	logic v_s1, range_s1, mark_s1;
	logic [qcci_pkg::SECTION_W-1:0] sec_s1;
	logic [qcci_pkg::CHARGE_W-1:0] q_s1;
	logic is_mark;

	// Classify the item
	always_comb begin
		ec_ok = (section == qcci_pkg::SEC_ENDCAP) &&
			({1'b0, counter} < (qcci_pkg::COUNTER_W + 1)'(qcci_pkg::ENDCAP_COUNTERS));
		br_ok = ((section == qcci_pkg::SEC_EAST) || (section == qcci_pkg::SEC_WEST)) &&
			({1'b0, counter} < (qcci_pkg::COUNTER_W + 1)'(qcci_pkg::BARREL_COUNTERS));
		in_range = ec_ok || br_ok;
		is_load  = take && (kind == qcci_pkg::KIND_LOAD);
		is_conv  = take && (kind == qcci_pkg::KIND_CONV);
		ec_addr  = counter[qcci_pkg::EC_AW-1:0];
		br_addr  = counter[qcci_pkg::BR_AW-1:0];
		wr_ec    = is_load && ec_ok;
		wr_ea    = is_load && br_ok && (section == qcci_pkg::SEC_EAST);
		wr_we    = is_load && br_ok && (section == qcci_pkg::SEC_WEST);
		rd_ec    = is_conv && ec_ok;
		rd_ea    = is_conv && br_ok && (section == qcci_pkg::SEC_EAST);
		rd_we    = is_conv && br_ok && (section == qcci_pkg::SEC_WEST);
		is_mark  = (longint'(charge_in) == qcci_pkg::MARK_HI_L) ||
			(longint'(charge_in) == qcci_pkg::ERR_L);
	end

	// One bank per coefficient index in each section
	for (genvar k = 0; k < 3; k++) begin : g_bank
		logic [qcci_pkg::COEF_W-1:0] ec_mem_q [qcci_pkg::ENDCAP_COUNTERS];
		logic [qcci_pkg::COEF_W-1:0] ea_mem_q [qcci_pkg::BARREL_COUNTERS];
		logic [qcci_pkg::COEF_W-1:0] we_mem_q [qcci_pkg::BARREL_COUNTERS];

		always_ff @(posedge clk) begin
			if (wr_ec && (coef_index == qcci_pkg::CIDX_W'(k))) begin
				ec_mem_q[ec_addr] <= coef_value;
			end
			if (rd_ec) begin
				ec_rd[k] <= ec_mem_q[ec_addr];
			end
		end

		always_ff @(posedge clk) begin
			if (wr_ea && (coef_index == qcci_pkg::CIDX_W'(k))) begin
				ea_mem_q[br_addr] <= coef_value;
			end
			if (rd_ea) begin
				ea_rd[k] <= ea_mem_q[br_addr];
			end
		end

		always_ff @(posedge clk) begin
			if (wr_we && (coef_index == qcci_pkg::CIDX_W'(k))) begin
				we_mem_q[br_addr] <= coef_value;
			end
			if (rd_we) begin
				we_rd[k] <= we_mem_q[br_addr];
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= is_conv;
		end
	end

	always_ff @(posedge clk) begin
		if (is_conv) begin
			sec_s1   <= section;
			range_s1 <= in_range;
			mark_s1  <= is_mark;
			q_s1     <= charge_in;
		end
	end

	// Item toward the queue; out-of-range and marker items are finished here
	always_comb begin
		item.ctl.valid  = v_s1;
		item.ctl.done   = !range_s1 || mark_s1;
		item.ctl.status = range_s1 ? qcci_pkg::ST_OK : qcci_pkg::ST_RANGE;
		item.ctl.value  = range_s1 ? q_s1 : qcci_pkg::ERR_VAL;
		item.q          = q_s1;
		unique case (sec_s1)
			qcci_pkg::SEC_EAST: begin
				item.c0 = ea_rd[0];
				item.b  = ea_rd[1];
				item.a  = ea_rd[2];
			end
			qcci_pkg::SEC_WEST: begin
				item.c0 = we_rd[0];
				item.b  = we_rd[1];
				item.a  = we_rd[2];
			end
			default: begin
				item.c0 = ec_rd[0];
				item.b  = ec_rd[1];
				item.a  = ec_rd[2];
			end
		endcase
	end

endmodule

// ===== design/qcci_fifo.sv =====
module qcci_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  qcci_pkg::fe_item_t push_item,
	output qcci_pkg::fe_item_t head,
	output logic               full
);

	qcci_pkg::fe_item_t mem_q [qcci_pkg::FIFO_DEPTH];
	logic [qcci_pkg::FA-1:0] wptr_q, rptr_q;
	logic [qcci_pkg::FA:0] cnt_q;
	logic push, pop;

	// The back end takes the head whenever there is one
	always_comb begin
		push = push_item.ctl.valid;
		pop  = (cnt_q != '0);
		full = (cnt_q == (qcci_pkg::FA + 1)'(qcci_pkg::FIFO_DEPTH));
		head = mem_q[rptr_q];
		head.ctl.valid = pop;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == qcci_pkg::FA'(qcci_pkg::FIFO_DEPTH - 1)) ? '0
					: wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == qcci_pkg::FA'(qcci_pkg::FIFO_DEPTH - 1)) ? '0
					: rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (qcci_pkg::FA + 1)'(push) - (qcci_pkg::FA + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	// No item arrives at a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("item pushed into full queue");

endmodule

// ===== design/qcci_back.sv =====
module qcci_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qcci_pkg::fe_item_t                   item,
	output logic                                 done,
	output logic [qcci_pkg::CHARGE_W-1:0]        raw_charge,
	output logic [1:0]                           status
);

	localparam int AW   = qcci_pkg::AW;
	localparam int MW   = qcci_pkg::MW;
	localparam int HW   = qcci_pkg::HW;
	localparam int PPW  = qcci_pkg::PPW;
	localparam int PW   = qcci_pkg::PW;
	localparam int DW   = qcci_pkg::DW;
	localparam int SQIN = qcci_pkg::SQIN;
	localparam int RB   = qcci_pkg::RB;
	localparam int RW   = qcci_pkg::RW;
	localparam int NW   = qcci_pkg::NW;
	localparam int NUMW = qcci_pkg::NUMW;
	localparam int DVW  = qcci_pkg::DVW;
	localparam int QB   = qcci_pkg::QB;
	localparam int TW   = qcci_pkg::TW;
	localparam int CMPW = qcci_pkg::CMPW;
	localparam int CW   = qcci_pkg::CHARGE_W;

	// Stage 1: scaled operands
	logic signed [AW-1:0] ax, bx, a5, b5;
	logic signed [MW-1:0] cx, qx, c5;
	qcci_pkg::ctl_t ctl_s1;
	logic signed [AW-1:0] a_s1, b_s1;
	logic signed [MW-1:0] c_s1;

	// Stage 2: signs and magnitudes
	logic [MW-1:0] mag_a, mag_b, mag_c;
	logic zero_a;
	qcci_pkg::ctl_t ctl_s2, ctl_n2;
	logic [MW-1:0] mag_a_s2, mag_b_s2, mag_c_s2;
	logic s_a_s2, s_ac_s2;
	logic signed [AW-1:0] b_s2;

	// Stage 3: partial products
	logic [HW-1:0] bh, bl, ah, al, ch, cl;
	qcci_pkg::ctl_t ctl_s3;
	logic [PPW-1:0] bb_hh_s3, bb_hl_s3, bb_ll_s3;
	logic [PPW-1:0] ac_hh_s3, ac_hl_s3, ac_lh_s3, ac_ll_s3;
	logic s_ac_s3;
	qcci_pkg::carry_t car_s3;

	// Stage 4: full products
	logic [PW-1:0] bb, ac;
	qcci_pkg::ctl_t ctl_s4;
	logic [PW-1:0] bb_s4, ac_s4;
	logic s_ac_s4;
	qcci_pkg::carry_t car_s4;

	// Stage 5: discriminant
	logic [DW-1:0] bbx, ac4, dd;
	qcci_pkg::ctl_t ctl_n5;

	// Square root pipe
	qcci_pkg::ctl_t   sq_ctl_s  [RB+1];
	qcci_pkg::carry_t sq_car_s  [RB+1];
	logic [RW-1:0]    sq_rem_s  [RB+1];
	logic [RB-1:0]    sq_root_s [RB+1];
	logic [SQIN-1:0]  sq_dsh_s  [RB+1];

	// Numerator stages
	qcci_pkg::ctl_t ctl_s6, ctl_s7;
	logic signed [NW-1:0] n_s6;
	qcci_pkg::carry_t car_s6;
	logic [NW-1:0] mag_n_s7;
	logic neg_s7;
	logic [MW-1:0] mag_a_s7;
	logic [NUMW-1:0] num;
	logic [DVW-1:0] dvs;
	logic [TW-1:0] top;
	logic ovf;

	// Divider pipe
	qcci_pkg::ctl_t dv_ctl_s [QB+1];
	logic [DVW-1:0] dv_rem_s [QB+1];
	logic [QB-1:0]  dv_quo_s [QB+1];
	logic [QB-1:0]  dv_num_s [QB+1];
	logic [DVW-1:0] dv_d_s   [QB+1];
	logic           dv_neg_s [QB+1];
	logic           dv_ov_s  [QB+1];

	// Output
	qcci_pkg::ctl_t fc;
	logic [QB-1:0] qf;
	logic [CW-1:0] val;
	logic [1:0] st;
	logic done_q;
	logic [CW-1:0] raw_q;
	logic [1:0] status_q;

	// Stage 1: A = 5a, B = 5b, C = 5c0 - 2q on the common scale
	always_comb begin
		ax = AW'($signed(item.a));
		bx = AW'($signed(item.b));
		cx = MW'($signed(item.c0));
		qx = MW'($signed(item.q));
		a5 = ((ax <<< 2) + ax) <<< qcci_pkg::SA;
		b5 = ((bx <<< 2) + bx) <<< qcci_pkg::SA;
		c5 = (((cx <<< 2) + cx) <<< qcci_pkg::SA) - (qx <<< (qcci_pkg::SQ + 1));
	end

	always_ff @(posedge clk) begin
		a_s1 <= a5;
		b_s1 <= b5;
		c_s1 <= c5;
	end

	// Stage 2
	always_comb begin
		mag_a  = a_s1[AW-1] ? MW'($unsigned(-a_s1)) : MW'($unsigned(a_s1));
		mag_b  = b_s1[AW-1] ? MW'($unsigned(-b_s1)) : MW'($unsigned(b_s1));
		mag_c  = c_s1[MW-1] ? $unsigned(-c_s1) : $unsigned(c_s1);
		zero_a = (a_s1 == '0);
		ctl_n2 = ctl_s1;
		if (ctl_s1.valid && !ctl_s1.done && zero_a) begin
			ctl_n2.done   = 1'b1;
			ctl_n2.status = qcci_pkg::ST_ZEROA;
			ctl_n2.value  = qcci_pkg::ERR_VAL;
		end
	end

	always_ff @(posedge clk) begin
		mag_a_s2 <= mag_a;
		mag_b_s2 <= mag_b;
		mag_c_s2 <= mag_c;
		s_a_s2   <= a_s1[AW-1];
		s_ac_s2  <= a_s1[AW-1] ^ c_s1[MW-1];
		b_s2     <= b_s1;
	end

	// Stage 3: half-width products
	always_comb begin
		bl = mag_b_s2[HW-1:0];
		bh = HW'(mag_b_s2[MW-1:HW]);
		al = mag_a_s2[HW-1:0];
		ah = HW'(mag_a_s2[MW-1:HW]);
		cl = mag_c_s2[HW-1:0];
		ch = HW'(mag_c_s2[MW-1:HW]);
	end

	always_ff @(posedge clk) begin
		bb_hh_s3 <= PPW'(bh) * PPW'(bh);
		bb_hl_s3 <= PPW'(bh) * PPW'(bl);
		bb_ll_s3 <= PPW'(bl) * PPW'(bl);
		ac_hh_s3 <= PPW'(ah) * PPW'(ch);
		ac_hl_s3 <= PPW'(ah) * PPW'(cl);
		ac_lh_s3 <= PPW'(al) * PPW'(ch);
		ac_ll_s3 <= PPW'(al) * PPW'(cl);
		s_ac_s3  <= s_ac_s2;
		car_s3   <= '{b: b_s2, mag_a: mag_a_s2, s_a: s_a_s2};
	end

	// Stage 4: combine partial products
	always_comb begin
		bb = (PW'(bb_hh_s3) << (2 * HW)) + (PW'(bb_hl_s3) << (HW + 1)) + PW'(bb_ll_s3);
		ac = (PW'(ac_hh_s3) << (2 * HW)) + ((PW'(ac_hl_s3) + PW'(ac_lh_s3)) << HW)
			+ PW'(ac_ll_s3);
	end

	always_ff @(posedge clk) begin
		bb_s4   <= bb;
		ac_s4   <= ac;
		s_ac_s4 <= s_ac_s3;
		car_s4  <= car_s3;
	end

	// Stage 5: D = B*B - 4*A*C
	always_comb begin
		bbx = DW'(bb_s4);
		ac4 = DW'(ac_s4) << 2;
		dd  = s_ac_s4 ? bbx + ac4 : bbx - ac4;
		ctl_n5 = ctl_s4;
		if (ctl_s4.valid && !ctl_s4.done && dd[DW-1]) begin
			ctl_n5.done   = 1'b1;
			ctl_n5.status = qcci_pkg::ST_NEGD;
			ctl_n5.value  = qcci_pkg::ERR_VAL;
		end
	end

	always_ff @(posedge clk) begin
		sq_car_s[0]  <= car_s4;
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		sq_dsh_s[0]  <= dd[SQIN-1:0];
	end

	// Control through stages 1 to 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			sq_ctl_s[0] <= '0;
		end else begin
			ctl_s1      <= item.ctl;
			ctl_s2      <= ctl_n2;
			ctl_s3      <= ctl_s2;
			ctl_s4      <= ctl_s3;
			sq_ctl_s[0] <= ctl_n5;
		end
	end

	// Square root: one root bit per stage
	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		logic [RW-1:0] r2, tr;
		logic ge;

		always_comb begin
			r2 = {sq_rem_s[i][RW-3:0], sq_dsh_s[i][SQIN-1 -: 2]};
			tr = {sq_root_s[i], 2'b01};
			ge = (r2 >= tr);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_ctl_s[i+1] <= '0;
			end else begin
				sq_ctl_s[i+1] <= sq_ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_car_s[i+1]  <= sq_car_s[i];
			sq_rem_s[i+1]  <= ge ? r2 - tr : r2;
			sq_root_s[i+1] <= {sq_root_s[i][RB-2:0], ge};
			sq_dsh_s[i+1]  <= sq_dsh_s[i] << 2;
		end
	end

	// Stage 6: N = root - B
	always_ff @(posedge clk) begin
		n_s6   <= $signed(NW'(sq_root_s[RB])) - NW'($signed(sq_car_s[RB].b));
		car_s6 <= sq_car_s[RB];
	end

	// Stage 7: |N| and result sign
	always_ff @(posedge clk) begin
		mag_n_s7 <= n_s6[NW-1] ? $unsigned(-n_s6) : $unsigned(n_s6);
		neg_s7   <= n_s6[NW-1] ^ car_s6.s_a;
		mag_a_s7 <= car_s6.mag_a;
	end

	// Stage 8: rounded numerator, divisor and overflow check
	always_comb begin
		num = (NUMW'(mag_n_s7) << qcci_pkg::CHARGE_FRAC_BITS) + NUMW'(mag_a_s7);
		dvs = DVW'(mag_a_s7) << 1;
		top = num[NUMW-1:QB];
		ovf = (CMPW'(top) >= CMPW'(dvs));
	end

	always_ff @(posedge clk) begin
		dv_rem_s[0] <= DVW'(top);
		dv_quo_s[0] <= '0;
		dv_num_s[0] <= num[QB-1:0];
		dv_d_s[0]   <= dvs;
		dv_neg_s[0] <= neg_s7;
		dv_ov_s[0]  <= ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6      <= '0;
			ctl_s7      <= '0;
			dv_ctl_s[0] <= '0;
		end else begin
			ctl_s6      <= sq_ctl_s[RB];
			ctl_s7      <= ctl_s6;
			dv_ctl_s[0] <= ctl_s7;
		end
	end

	// Restoring divider: one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [DVW:0] r, rd;
		logic ge;

		always_comb begin
			r  = {dv_rem_s[j], dv_num_s[j][QB-1]};
			ge = (r >= {1'b0, dv_d_s[j]});
			rd = r - {1'b0, dv_d_s[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_ctl_s[j+1] <= '0;
			end else begin
				dv_ctl_s[j+1] <= dv_ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s[j+1] <= ge ? rd[DVW-1:0] : r[DVW-1:0];
			dv_quo_s[j+1] <= {dv_quo_s[j][QB-2:0], ge};
			dv_num_s[j+1] <= dv_num_s[j] << 1;
			dv_d_s[j+1]   <= dv_d_s[j];
			dv_neg_s[j+1] <= dv_neg_s[j];
			dv_ov_s[j+1]  <= dv_ov_s[j];
		end
	end

	// Sign and saturation
	always_comb begin
		fc = dv_ctl_s[QB];
		qf = dv_quo_s[QB];
		st = qcci_pkg::ST_OK;
		priority if (fc.done) begin
			val = fc.value;
			st  = fc.status;
		end else if (dv_neg_s[QB]) begin
			if (dv_ov_s[QB] || (qf > QB'(64'h8000_0000))) begin
				val = 32'h8000_0000;
			end else begin
				val = -qf[CW-1:0];
			end
		end else begin
			if (dv_ov_s[QB] || (qf > QB'(64'h7FFF_FFFF))) begin
				val = 32'h7FFF_FFFF;
			end else begin
				val = qf[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fc.valid;
		end
	end

	always_ff @(posedge clk) begin
		raw_q    <= val;
		status_q <= st;
	end

	assign done       = done_q;
	assign raw_charge = raw_q;
	assign status     = status_q;

	// An item flagged with negative discriminant was live and unfinished in stage 4
	a_negd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		sq_ctl_s[0].valid && (sq_ctl_s[0].status == qcci_pkg::ST_NEGD)
		|-> $past(ctl_s4.valid && !ctl_s4.done))
		else $error("negative discriminant flagged on a finished item");

endmodule

// ===== design/quadratic_charge_calibration_inverse_unit.sv =====
// Inverse quadratic charge calibration.
// Input channel: an item is taken at a rising edge with start high and busy low.
//   kind = load writes coef_value into coefficient coef_index of the given
//   section and counter; a load with a bad section, counter or index is dropped
//   and no load gives a result.
//   kind = convert solves a*x*x + b*x + c0 - 0.4*charge_in = 0 for the raw charge.
// Result channel: done is high for one cycle with raw_charge and status; the
//   receiver cannot hold results off. Results leave in the order items came in.
// A convert result goes through the queue, back stages 1 to 5, the square root pipe,
//   stages 6 to 8 and the divider pipe, whatever its status. The pipe takes one item
//   per cycle: the 53-stage square root and 33-stage divider pipes each retire one a cycle.
// A load seen at one edge is visible to a convert taken at the next edge.
// busy rises only if the two-entry queue between the store lookup and the
//   arithmetic pipe fills.
// Reset clears all pipe control and the queue; coefficient stores keep no
//   reset value and must be loaded before use.
module quadratic_charge_calibration_inverse_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  kind,
	input  logic [qcci_pkg::SECTION_W-1:0]        section,
	input  logic [qcci_pkg::COUNTER_W-1:0]        counter,
	input  logic [qcci_pkg::CIDX_W-1:0]           coef_index,
	input  logic signed [qcci_pkg::COEF_W-1:0]    coef_value,
	input  logic signed [qcci_pkg::CHARGE_W-1:0]  charge_in,
	output logic                                  done,
	output logic signed [qcci_pkg::CHARGE_W-1:0]  raw_charge,
	output logic [1:0]                            status
);

	logic take, full;
	qcci_pkg::fe_item_t fe_item, head;
	logic [qcci_pkg::CHARGE_W-1:0] raw_u;

	assign take = start && !busy;
	assign busy = full;

	qcci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.kind       (kind),
		.section    (section),
		.counter    (counter),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.charge_in  (charge_in),
		.item       (fe_item)
	);

	qcci_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_item (fe_item),
		.head      (head),
		.full      (full)
	);

	qcci_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (head),
		.done       (done),
		.raw_charge (raw_u),
		.status     (status)
	);

	assign raw_charge = $signed(raw_u);

	// Every convert produces its result a fixed time later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == qcci_pkg::KIND_CONV) |-> ##(qcci_pkg::LATENCY) done)
		else $error("convert result missing at expected cycle");

	// Any error status carries the error charge
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != qcci_pkg::ST_OK) |-> raw_u == qcci_pkg::ERR_VAL)
		else $error("error status without error charge");

endmodule
